### hw/rtl/bmpb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmpb_pkg: shared types and constants of the clipped bitmap blitter
// Screen and image limits, register indexes and the structs that carry the
// register file, the derived setup and the input-stage request.
// ----------------------------------------------------------------------------
package bmpb_pkg;

    // Screen size and largest image dimension.
    localparam int SCR_W   = 220;
    localparam int SCR_H   = 176;
    localparam int MAX_DIM = 1024;

    // Configuration port widths.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_X        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_Y        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_W        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_H        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_X       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_Y       = 3'd7;

    // Register file contents.
    typedef struct packed {
        logic [10:0] image_width;
        logic [11:0] image_height;  // two's complement
        logic [9:0]  src_x;
        logic [9:0]  src_y;
        logic [10:0] src_w;
        logic [10:0] src_h;
        logic [10:0] dest_x;        // two's complement
        logic [10:0] dest_y;        // two's complement
    } t_cfg;

    // Values derived from the registers.
    typedef struct packed {
        logic        ok;         // setup is valid
        logic        bottom_up;  // image_height is positive
        logic [10:0] ew;         // width used for counting
        logic [10:0] eh;         // height used for counting
        logic [10:0] iw;         // effective rectangle width
        logic [11:0] ih;         // effective rectangle height
    } t_setup;

    // Request held in the input register.
    typedef struct packed {
        logic [23:0] pixel;
        logic [9:0]  col;
        logic [11:0] row;        // image row, two's complement
        logic        err;        // emit the error result
        logic        cand;       // setup valid and frame not failed
    } t_req;

endpackage
`default_nettype wire

### hw/rtl/bmp24_clipped_blit_rgb565.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmp24_clipped_blit_rgb565: clipped blit of 24-bit bitmap pixels to RGB565
// Places unpadded file-order pixels in the image, clips them to the source
// rectangle and the 220 x 176 screen and emits screen position and color.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock cycle while the input does not stall.
// Each accepted pixel is captured in the input register, where the column and
// row counters tag the pixel, and its result is then loaded into the result
// register after the rectangle, screen and color logic. A pixel that produces
// no result leaves the input register without using the result register, so
// the input stalls only while a result waits and the pixel behind it also
// produces one. Write the registers only while no request is in flight; an
// invalid setup yields one error request and the rest of the frame is dropped.
module bmp24_clipped_blit_rgb565 (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [bmpb_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [bmpb_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                             i_valid,
    output logic                                  o_stall,
    input  wire logic [23:0]                      i_pixel_bgr,
    output logic                                  o_valid,
    input  wire logic                             i_stall,
    output logic [7:0]                            o_screen_x,
    output logic [7:0]                            o_screen_y,
    output logic [15:0]                           o_color,
    output logic                                  o_error
);

    bmpb_pkg::t_cfg   cfg;
    bmpb_pkg::t_setup setup;
    bmpb_pkg::t_req   req;
    logic             req_valid;
    logic             take;

    // Register file.
    bmpb_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg),
        .o_setup    (setup)
    );

    // Position tracking and input register.
    bmpb_track u_track (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_pixel_bgr (i_pixel_bgr),
        .o_stall     (o_stall),
        .i_setup     (setup),
        .i_take      (take),
        .o_req_valid (req_valid),
        .o_req       (req)
    );

    // Clipping and result register.
    bmpb_map u_map (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_setup     (setup),
        .i_req_valid (req_valid),
        .i_req       (req),
        .o_take      (take),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_screen_x  (o_screen_x),
        .o_screen_y  (o_screen_y),
        .o_color     (o_color),
        .o_error     (o_error)
    );

endmodule
`default_nettype wire

### hw/rtl/bmpb_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmpb_cfg: configuration registers and setup check
// Holds the eight registers and derives the counting dimensions, the
// effective rectangle size and the validity of the setup.
// ----------------------------------------------------------------------------
module bmpb_cfg (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [bmpb_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [bmpb_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output bmpb_pkg::t_cfg                        o_cfg,
    output bmpb_pkg::t_setup                      o_setup
);

    bmpb_pkg::t_cfg r_cfg;
    bmpb_pkg::t_cfg n_cfg;

    logic [11:0] ah;
    logic [10:0] iw;
    logic [11:0] ih;
    logic        w_ok;
    logic        h_ok;
    logic [11:0] sum_x;
    logic [12:0] sum_y;
    logic [13:0] dx;
    logic [13:0] dy;
    logic [13:0] dx_lo;
    logic [13:0] dy_lo;
    logic        dx_ok;
    logic        dy_ok;

    // Register writes.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                bmpb_pkg::REG_IMAGE_WIDTH:  n_cfg.image_width  = i_cfg_data[10:0];
                bmpb_pkg::REG_IMAGE_HEIGHT: n_cfg.image_height = i_cfg_data[11:0];
                bmpb_pkg::REG_SRC_X:        n_cfg.src_x        = i_cfg_data[9:0];
                bmpb_pkg::REG_SRC_Y:        n_cfg.src_y        = i_cfg_data[9:0];
                bmpb_pkg::REG_SRC_W:        n_cfg.src_w        = i_cfg_data[10:0];
                bmpb_pkg::REG_SRC_H:        n_cfg.src_h        = i_cfg_data[10:0];
                bmpb_pkg::REG_DEST_X:       n_cfg.dest_x       = i_cfg_data[10:0];
                bmpb_pkg::REG_DEST_Y:       n_cfg.dest_y       = i_cfg_data[10:0];
                default:                    n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width  <= 11'd1;
            r_cfg.image_height <= 12'd1;
            r_cfg.src_x        <= 10'd0;
            r_cfg.src_y        <= 10'd0;
            r_cfg.src_w        <= 11'd0;
            r_cfg.src_h        <= 11'd0;
            r_cfg.dest_x       <= 11'd0;
            r_cfg.dest_y       <= 11'd0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Absolute height and effective rectangle size.
    assign ah = r_cfg.image_height[11] ? (12'd0 - r_cfg.image_height) : r_cfg.image_height;
    assign iw = (r_cfg.src_w != 11'd0) ? r_cfg.src_w : r_cfg.image_width;
    assign ih = (r_cfg.src_h != 11'd0) ? {1'b0, r_cfg.src_h} : ah;

    // Dimension ranges and rectangle fit inside the image.
    assign w_ok  = (r_cfg.image_width != 11'd0) &&
                   (r_cfg.image_width <= 11'(bmpb_pkg::MAX_DIM));
    assign h_ok  = (ah != 12'd0) && (ah <= 12'(bmpb_pkg::MAX_DIM));
    assign sum_x = {2'b00, r_cfg.src_x} + {1'b0, iw};
    assign sum_y = {3'b000, r_cfg.src_y} + {1'b0, ih};

    // Destination range: minus the rectangle size .. screen size minus one.
    assign dx    = {{3{r_cfg.dest_x[10]}}, r_cfg.dest_x};
    assign dy    = {{3{r_cfg.dest_y[10]}}, r_cfg.dest_y};
    assign dx_lo = dx + {3'b000, iw};
    assign dy_lo = dy + {2'b00, ih};
    assign dx_ok = ($signed(dx) <= $signed(14'(bmpb_pkg::SCR_W - 1))) && !dx_lo[13];
    assign dy_ok = ($signed(dy) <= $signed(14'(bmpb_pkg::SCR_H - 1))) && !dy_lo[13];

    // Derived setup.
    always_comb begin
        o_setup.ok        = w_ok && h_ok && (sum_x <= {1'b0, r_cfg.image_width}) &&
                            (sum_y <= {1'b0, ah}) && dx_ok && dy_ok;
        o_setup.bottom_up = !r_cfg.image_height[11] && (r_cfg.image_height != 12'd0);
        o_setup.iw        = iw;
        o_setup.ih        = ih;
        if (r_cfg.image_width == 11'd0) begin
            o_setup.ew = 11'd1;
        end else if (r_cfg.image_width > 11'(bmpb_pkg::MAX_DIM)) begin
            o_setup.ew = 11'(bmpb_pkg::MAX_DIM);
        end else begin
            o_setup.ew = r_cfg.image_width;
        end
        if (ah == 12'd0) begin
            o_setup.eh = 11'd1;
        end else if (ah > 12'(bmpb_pkg::MAX_DIM)) begin
            o_setup.eh = 11'(bmpb_pkg::MAX_DIM);
        end else begin
            o_setup.eh = ah[10:0];
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

### hw/rtl/bmpb_track.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmpb_track: pixel position tracking and input register
// Counts columns and file rows, tracks the failed-frame flag and captures
// each accepted pixel with its image position into the input register.
// ----------------------------------------------------------------------------
module bmpb_track (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic [23:0]      i_pixel_bgr,
    output logic                  o_stall,
    input  wire bmpb_pkg::t_setup i_setup,
    input  wire logic             i_take,
    output logic                  o_req_valid,
    output bmpb_pkg::t_req        o_req
);

    logic           r_valid;
    logic           n_valid;
    bmpb_pkg::t_req r_req;
    logic [9:0]     r_col;
    logic [9:0]     n_col;
    logic [9:0]     r_row;
    logic [9:0]     n_row;
    logic           r_failed;
    logic           n_failed;

    logic           accept;
    logic [10:0]    col_inc;
    logic [10:0]    row_inc;
    logic           col_wrap;
    logic           frame_end;
    logic           err;
    logic [11:0]    img_row;

    // Handshake: the register frees up when its request moves on.
    assign o_stall = r_valid && !i_take;
    assign accept  = i_valid && !o_stall;

    // Counter wrap at the end of a row and of the frame.
    assign col_inc   = {1'b0, r_col} + 11'd1;
    assign row_inc   = {1'b0, r_row} + 11'd1;
    assign col_wrap  = col_inc >= i_setup.ew;
    assign frame_end = col_wrap && (row_inc >= i_setup.eh);
    assign err       = !r_failed && !i_setup.ok;

    // Image row from the file row, flipped for bottom-up images.
    assign img_row = i_setup.bottom_up ?
                     ({1'b0, i_setup.eh} - 12'd1 - {2'b00, r_row}) : {2'b00, r_row};

    always_comb begin
        n_col    = r_col;
        n_row    = r_row;
        n_failed = r_failed;
        n_valid  = r_valid && !i_take;
        if (accept) begin
            n_valid  = 1'b1;
            n_col    = col_wrap ? 10'd0 : col_inc[9:0];
            if (col_wrap) begin
                n_row = frame_end ? 10'd0 : row_inc[9:0];
            end
            n_failed = frame_end ? 1'b0 : (r_failed || err);
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_col    <= 10'd0;
            r_row    <= 10'd0;
            r_failed <= 1'b0;
        end else begin
            r_valid  <= n_valid;
            r_col    <= n_col;
            r_row    <= n_row;
            r_failed <= n_failed;
        end
    end

    // Input register payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req.pixel <= i_pixel_bgr;
            r_req.col   <= r_col;
            r_req.row   <= img_row;
            r_req.err   <= err;
            r_req.cand  <= !r_failed && i_setup.ok;
        end
    end

    assign o_req_valid = r_valid;
    assign o_req       = r_req;

endmodule
`default_nettype wire

### hw/rtl/bmpb_map.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmpb_map: clipping, screen mapping and result register
// Tests a request against the source rectangle and the screen, converts the
// color to RGB565 and loads the result register.
// ----------------------------------------------------------------------------
module bmpb_map (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire bmpb_pkg::t_cfg   i_cfg,
    input  wire bmpb_pkg::t_setup i_setup,
    input  wire logic             i_req_valid,
    input  wire bmpb_pkg::t_req   i_req,
    output logic                  o_take,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output logic [7:0]            o_screen_x,
    output logic [7:0]            o_screen_y,
    output logic [15:0]           o_color,
    output logic                  o_error
);

    logic        r_valid;
    logic        n_valid;
    logic [7:0]  r_x;
    logic [7:0]  r_y;
    logic [15:0] r_color;
    logic        r_error;

    logic [11:0] end_x;
    logic [13:0] end_y;
    logic [13:0] row;
    logic        in_rect;
    logic [13:0] sx;
    logic [13:0] sy;
    logic        on_screen;
    logic        emit;
    logic        room;
    logic        load;
    logic [15:0] rgb;

    // Source rectangle test.
    assign end_x   = {2'b00, i_cfg.src_x} + {1'b0, i_setup.iw};
    assign end_y   = {4'b0000, i_cfg.src_y} + {2'b00, i_setup.ih};
    assign row     = {{2{i_req.row[11]}}, i_req.row};
    assign in_rect = (i_req.col >= i_cfg.src_x) && ({2'b00, i_req.col} < end_x) &&
                     ($signed(row) >= $signed({4'b0000, i_cfg.src_y})) &&
                     ($signed(row) < $signed(end_y));

    // Screen position and screen test.
    assign sx = {{3{i_cfg.dest_x[10]}}, i_cfg.dest_x} + {4'b0000, i_req.col} -
                {4'b0000, i_cfg.src_x};
    assign sy = {{3{i_cfg.dest_y[10]}}, i_cfg.dest_y} + row - {4'b0000, i_cfg.src_y};
    assign on_screen = !sx[13] && (sx[12:0] < 13'(bmpb_pkg::SCR_W)) &&
                       !sy[13] && (sy[12:0] < 13'(bmpb_pkg::SCR_H));

    // RGB888 to RGB565.
    assign rgb = {i_req.pixel[23:19], i_req.pixel[15:10], i_req.pixel[7:3]};

    // A request without a result leaves at once; one with a result needs room.
    assign emit   = i_req.err || (i_req.cand && in_rect && on_screen);
    assign room   = !r_valid || !i_stall;
    assign o_take = i_req_valid && (!emit || room);
    assign load   = i_req_valid && emit && room;

    always_comb begin
        n_valid = r_valid && i_stall;
        if (load) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Result register payload; the error result carries zero fields.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_error <= i_req.err;
            r_x     <= i_req.err ? 8'd0 : sx[7:0];
            r_y     <= i_req.err ? 8'd0 : sy[7:0];
            r_color <= i_req.err ? 16'd0 : rgb;
        end
    end

    assign o_valid    = r_valid;
    assign o_screen_x = r_x;
    assign o_screen_y = r_y;
    assign o_color    = r_color;
    assign o_error    = r_error;

endmodule
`default_nettype wire

### hw/rtl/bmpb_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmpb_checker: port-level checks of the blitter
// Watches the top-level ports for result content, stall behavior and reset.
// ----------------------------------------------------------------------------
module bmpb_checker (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             o_valid,
    input  wire logic                             i_stall,
    input  wire logic [7:0]                       o_screen_x,
    input  wire logic [7:0]                       o_screen_y,
    input  wire logic [15:0]                      o_color,
    input  wire logic                             o_error
);

    // The error result carries zero pixel fields.
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error |-> o_screen_x == 8'd0 && o_screen_y == 8'd0 && o_color == 16'd0)
        else $error("error result with nonzero fields");

    // A pixel result always lies on the screen.
    a_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_error |->
            o_screen_x < 8'(bmpb_pkg::SCR_W) && o_screen_y < 8'(bmpb_pkg::SCR_H))
        else $error("pixel result off screen");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_screen_x) && $stable(o_screen_y) &&
            $stable(o_color) && $stable(o_error))
        else $error("stalled result changed");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind bmp24_clipped_blit_rgb565 bmpb_checker u_bmpb_checker (.*);
`default_nettype wire
